/* design/crb_pkg.sv */
// ----------------------------------------------------------------------------
// crb_pkg
// Types, constants and helpers shared by the Catmull-Rom to Bezier converter.
// ----------------------------------------------------------------------------
package crb_pkg;

   localparam int COORD_BITS  = 16;
   localparam int QUEUE_DEPTH = 4;

   // floor(m / 6) for m < 2**COORD_BITS is (m * RECIP) >> RECIP_SHIFT.
   localparam int RECIP_SHIFT = COORD_BITS + 3;
   localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6;
   localparam logic [COORD_BITS:0] RECIP = RECIP_FULL[COORD_BITS:0];

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef enum logic [1:0] {
      ROLE_START = 2'd0,
      ROLE_CTRL1 = 2'd1,
      ROLE_CTRL2 = 2'd2,
      ROLE_END   = 2'd3
   } role_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      last;
   } req_type;

   typedef struct packed {
      coord_type cx;
      coord_type cy;
      coord_type cz;
      role_type  role;
      logic      end_of_run;
      logic      too_few;
   } rsp_type;

   // One segment from p1 to p2 with neighbors p0 and p3. When closing is set,
   // the closing segment (p1, p2, p3, p3) follows it.
   typedef struct packed {
      point_type p0;
      point_type p1;
      point_type p2;
      point_type p3;
      logic      closing;
      logic      too_few;
   } job_type;

   function automatic coord_type pt_axis(point_type p, logic [1:0] a);
      coord_type r;
      case (a)
         2'd0:    r = p.x;
         2'd1:    r = p.y;
         default: r = p.z;
      endcase
      return r;
   endfunction

endpackage

/* design/crb_front.sv */
// ----------------------------------------------------------------------------
// crb_front
// Accepts points, keeps the window of earlier points and turns each point
// into at most one segment job for the back end.
// ----------------------------------------------------------------------------
module crb_front
   import crb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    job_push,
   output job_type job_data,
   input  logic    job_full
);

   logic [1:0] seen_ff, seen_in;
   point_type  win_ff [3];
   point_type  win_in [3];
   point_type  pt;
   logic       accept;

   assign full   = job_full;
   assign accept = push && !job_full;
   assign pt     = '{x: req_data.x, y: req_data.y, z: req_data.z};

   always_comb begin
      seen_in  = seen_ff;
      win_in   = win_ff;
      job_push = 1'b0;
      job_data = '0;
      if (seen_ff < 2'd2) begin
         job_data.too_few = 1'b1;
         job_push         = accept && req_data.last;
      end else begin
         job_data.closing = req_data.last;
         job_push         = accept;
         job_data.p3      = pt;
         if (seen_ff == 2'd2) begin
            // First segment: the start anchor is its own left neighbor.
            job_data.p0 = win_ff[0];
            job_data.p1 = win_ff[0];
            job_data.p2 = win_ff[1];
         end else begin
            job_data.p0 = win_ff[0];
            job_data.p1 = win_ff[1];
            job_data.p2 = win_ff[2];
         end
      end

      if (accept) begin
         if (req_data.last) begin
            seen_in = 2'd0;
         end else if (seen_ff == 2'd3) begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = pt;
         end else begin
            win_in[seen_ff] = pt;
            seen_in         = seen_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'd0;
      end else begin
         seen_ff <= seen_in;
      end
      win_ff <= win_in;
   end

endmodule

/* design/crb_queue.sv */
// ----------------------------------------------------------------------------
// crb_queue
// Short first-in first-out queue of segment jobs between front and back.
// ----------------------------------------------------------------------------
module crb_queue
   import crb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_push,
   input  job_type wr_data,
   output logic    wr_full,
   output logic    rd_valid,
   output job_type rd_data,
   input  logic    rd_take
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_wr, do_rd;

   assign wr_full  = (count_ff == CntW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_push && !wr_full;
   assign do_rd    = rd_take && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* design/crb_back.sv */
// ----------------------------------------------------------------------------
// crb_back
// Walks each segment job through its control points and computes them in a
// three-register pipeline: difference, divide by six, add and saturate.
// ----------------------------------------------------------------------------
module crb_back
   import crb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job_data,
   output logic    job_take,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   localparam int W = COORD_BITS;

   typedef struct packed {
      point_type          anchor;
      logic [2:0][W-1:0]  mag;
      logic [2:0]         sub;
      role_type           role;
      logic               eor;
      logic               too_few;
   } s1_type;

   typedef struct packed {
      point_type          anchor;
      logic [2:0][W-1:0]  quo;
      logic [2:0]         sub;
      role_type           role;
      logic               eor;
      logic               too_few;
   } s2_type;

   job_type  job_ff, job_in;
   logic     job_v_ff, job_v_in;
   role_type role_ff, role_in;
   logic     second_ff, second_in;

   s1_type   s1_ff, s1_in;
   logic     s1_v_ff, s1_v_in;
   s2_type   s2_ff, s2_in;
   logic     s2_v_ff, s2_v_in;
   rsp_type  rsp_ff, rsp_in;
   logic     rsp_v_ff, rsp_v_in;

   logic      out_rdy, s2_rdy, s1_rdy, issue, finish;
   point_type anchor_pt, hi_pt, lo_pt;
   logic      use_ctl, minus;

   assign out_rdy = !rsp_v_ff || pop;
   assign s2_rdy  = !s2_v_ff || out_rdy;
   assign s1_rdy  = !s1_v_ff || s2_rdy;
   assign issue   = job_v_ff && s1_rdy;

   // A job ends after its error result, or after the end anchor of its final
   // segment.
   assign finish  = job_ff.too_few ||
                    ((role_ff == ROLE_END) && !(job_ff.closing && !second_ff));
   assign job_take = job_valid && (!job_v_ff || (issue && finish));

   always_comb begin
      anchor_pt = job_ff.p1;
      hi_pt     = job_ff.p2;
      lo_pt     = job_ff.p0;
      use_ctl   = 1'b0;
      minus     = 1'b0;
      unique case (role_ff)
         ROLE_START: begin
            anchor_pt = job_ff.p1;
         end
         ROLE_CTRL1: begin
            anchor_pt = job_ff.p1;
            hi_pt     = job_ff.p2;
            lo_pt     = job_ff.p0;
            use_ctl   = 1'b1;
         end
         ROLE_CTRL2: begin
            anchor_pt = job_ff.p2;
            hi_pt     = job_ff.p3;
            lo_pt     = job_ff.p1;
            use_ctl   = 1'b1;
            minus     = 1'b1;
         end
         ROLE_END: begin
            anchor_pt = job_ff.p2;
         end
         default: begin
            anchor_pt = job_ff.p1;
         end
      endcase
      if (job_ff.too_few) begin
         anchor_pt = '0;
         use_ctl   = 1'b0;
      end
   end

   always_comb begin
      job_in    = job_ff;
      job_v_in  = job_v_ff;
      role_in   = role_ff;
      second_in = second_ff;
      if (issue) begin
         if (finish) begin
            job_v_in = 1'b0;
         end else if (role_ff == ROLE_END) begin
            // Move on to the closing segment, whose right neighbor is its end.
            job_in.p0 = job_ff.p1;
            job_in.p1 = job_ff.p2;
            job_in.p2 = job_ff.p3;
            role_in   = ROLE_START;
            second_in = 1'b1;
         end else begin
            role_in = role_type'(role_ff + 2'd1);
         end
      end
      if (job_take) begin
         job_in    = job_data;
         job_v_in  = 1'b1;
         role_in   = ROLE_START;
         second_in = 1'b0;
      end
   end

   // Stage 1: neighbor difference as magnitude and effective sign.
   assign s1_in.anchor  = anchor_pt;
   assign s1_in.role    = job_ff.too_few ? ROLE_START : role_ff;
   assign s1_in.eor     = finish;
   assign s1_in.too_few = job_ff.too_few;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      coord_type          hi_c, lo_c;
      logic signed [W:0]  diff;
      logic        [W:0]  neg;
      logic [2*W:0]       prod;
      logic signed [W:0]  sum;
      coord_type          sat_c;

      assign hi_c = pt_axis(hi_pt, 2'(a));
      assign lo_c = pt_axis(lo_pt, 2'(a));
      assign diff = {hi_c[W-1], hi_c} - {lo_c[W-1], lo_c};
      assign neg  = -diff;
      assign s1_in.mag[a] = !use_ctl ? '0 : (diff[W] ? neg[W-1:0] : diff[W-1:0]);
      assign s1_in.sub[a] = diff[W] ^ minus;

      // Stage 2: floor of magnitude over six by reciprocal multiplication.
      assign prod = (2*W+1)'(s1_ff.mag[a]) * (2*W+1)'(RECIP);
      assign s2_in.quo[a] = {2'b00, prod[2*W:RECIP_SHIFT]};

      // Output stage: add the signed quotient and saturate.
      always_comb begin
         coord_type anc;
         anc = pt_axis(s2_ff.anchor, 2'(a));
         if (s2_ff.sub[a]) begin
            sum = {anc[W-1], anc} - {1'b0, s2_ff.quo[a]};
         end else begin
            sum = {anc[W-1], anc} + {1'b0, s2_ff.quo[a]};
         end
         if (sum[W] != sum[W-1]) begin
            sat_c = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else begin
            sat_c = sum[W-1:0];
         end
      end

      if (a == 0) begin : g_x
         assign rsp_in.cx = sat_c;
      end else if (a == 1) begin : g_y
         assign rsp_in.cy = sat_c;
      end else begin : g_z
         assign rsp_in.cz = sat_c;
      end
   end

   assign s2_in.anchor  = s1_ff.anchor;
   assign s2_in.sub     = s1_ff.sub;
   assign s2_in.role    = s1_ff.role;
   assign s2_in.eor     = s1_ff.eor;
   assign s2_in.too_few = s1_ff.too_few;

   assign rsp_in.role       = s2_ff.role;
   assign rsp_in.end_of_run = s2_ff.eor;
   assign rsp_in.too_few    = s2_ff.too_few;

   assign s1_v_in  = s1_rdy  ? issue   : s1_v_ff;
   assign s2_v_in  = s2_rdy  ? s1_v_ff : s2_v_ff;
   assign rsp_v_in = out_rdy ? s2_v_ff : rsp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_v_ff  <= 1'b0;
         role_ff   <= ROLE_START;
         second_ff <= 1'b0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         job_v_ff  <= job_v_in;
         role_ff   <= role_in;
         second_ff <= second_in;
         s1_v_ff   <= s1_v_in;
         s2_v_ff   <= s2_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
      job_ff <= job_in;
      if (s1_rdy) begin
         s1_ff <= s1_in;
      end
      if (s2_rdy) begin
         s2_ff <= s2_in;
      end
      if (out_rdy) begin
         rsp_ff <= rsp_in;
      end
   end

   assign empty    = !rsp_v_ff;
   assign rsp_data = rsp_ff;

endmodule

/* design/catmull_rom_to_bezier_unit.sv */
// ----------------------------------------------------------------------------
// catmull_rom_to_bezier_unit
// Converts a stream of Catmull-Rom points into cubic Bezier control points.
// ----------------------------------------------------------------------------
// Usage:
// Points enter on the request queue port: a transfer happens when push is
// high and full is low. Results leave on the response queue port: the oldest
// control point is on rsp_data while empty is low, and pop takes it.
// From the third point of a curve on, every point gives four results (start
// anchor, first control, second control, end anchor). The last point of a
// curve with at least three points gives eight; a curve shorter than three
// points gives one result flagged too_few. end_of_run marks the final result
// of each point.
// A point passes through the job queue, the job register and the three
// pipeline registers before its first result is ready. Throughput is one
// result per cycle while pop keeps up; the single result port sets that rate.
// A queue of segment jobs sits between the point window and the result
// pipeline, so points are still taken while results wait to be popped; when
// the receiver stalls, the pipeline and then the job queue fill and full
// rises. Reset clears the window, the queue and the pipeline at once.
// ----------------------------------------------------------------------------
module catmull_rom_to_bezier_unit
   import crb_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    fq_push, fq_full, qb_valid, qb_take;
   job_type fq_data, qb_data;

   crb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .job_push (fq_push),
      .job_data (fq_data),
      .job_full (fq_full)
   );

   crb_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (fq_push),
      .wr_data  (fq_data),
      .wr_full  (fq_full),
      .rd_valid (qb_valid),
      .rd_data  (qb_data),
      .rd_take  (qb_take)
   );

   crb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_data  (qb_data),
      .job_take  (qb_take),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
